### design/tct_pkg.sv
// shared types, constants and the arctangent table of the tilt cursor tracker
package tct_pkg;

  localparam int SLOT_COUNT = 8;
  localparam int SLOT_W = 3;
  localparam int COUNT_W = $clog2(SLOT_COUNT + 1);
  localparam int FRAC_BITS = 8;
  localparam int ANGLE_W = 17;
  localparam int SAMPLE_W = 16;
  localparam int POS_W = 12;
  localparam int LIMIT_W = 13;
  localparam int GAIN_W = 6;
  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W = 4;
  localparam int VEC_W = 28;
  localparam int Z_W = 26;
  localparam int QUEUE_DEPTH = 2;
  // angle times gain, and cursor position plus movement
  localparam int PROD_W = ANGLE_W + GAIN_W + 1;
  localparam int P_W = POS_W + 5;

  localparam logic [LIMIT_W-1:0] LIMIT_MAX = 13'd4096;
  localparam logic signed [ANGLE_W-1:0] ANGLE_FULL = 17'sd46080;
  localparam logic signed [ANGLE_W-1:0] ANGLE_QUARTER = 17'sd23040;
  localparam logic signed [Z_W-1:0] Z_QUARTER = 26'sd5898240;

  localparam logic [1:0] REG_SCREEN_WIDTH = 2'd0;
  localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd1;
  localparam logic [1:0] REG_MOTION_GAIN = 2'd2;

  typedef enum logic [1:0] {
    ST_MOVED = 2'd0,
    ST_PLUGGED = 2'd1,
    ST_FULL = 2'd2,
    ST_NO_SLOT = 2'd3
  } status_t;

  typedef struct packed {
    status_t kind;
    logic [SLOT_W-1:0] slot;
    logic signed [SAMPLE_W-1:0] accel_x;
    logic signed [SAMPLE_W-1:0] accel_y;
    logic signed [SAMPLE_W-1:0] accel_z;
    logic signed [SAMPLE_W-1:0] gyro_z;
  } cmd_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_PITCH,
    B_ROLL,
    B_SCALE,
    B_MOVE,
    B_DONE
  } back_state_t;

  // atan(2^-i) in degrees, Q16
  function automatic logic signed [Z_W-1:0] atan_step(input logic [STEP_W-1:0] i);
    logic signed [Z_W-1:0] v;
    case (i)
      4'd0: v = 26'sd2949120;
      4'd1: v = 26'sd1740967;
      4'd2: v = 26'sd919879;
      4'd3: v = 26'sd466945;
      4'd4: v = 26'sd234379;
      4'd5: v = 26'sd117304;
      4'd6: v = 26'sd58666;
      4'd7: v = 26'sd29335;
      4'd8: v = 26'sd14668;
      4'd9: v = 26'sd7334;
      4'd10: v = 26'sd3667;
      4'd11: v = 26'sd1833;
      4'd12: v = 26'sd917;
      4'd13: v = 26'sd458;
      4'd14: v = 26'sd229;
      4'd15: v = 26'sd115;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

### design/tct_front.sv
// front end: accepts requests, tracks plugged slots and classifies each request
module tct_front (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic req_type,
  input  logic [tct_pkg::SLOT_W-1:0] slot_index,
  input  logic signed [tct_pkg::SAMPLE_W-1:0] accel_x,
  input  logic signed [tct_pkg::SAMPLE_W-1:0] accel_y,
  input  logic signed [tct_pkg::SAMPLE_W-1:0] accel_z,
  input  logic signed [tct_pkg::SAMPLE_W-1:0] gyro_z,
  input  logic q_full,
  output logic q_push,
  output tct_pkg::cmd_t q_cmd
);

  logic [tct_pkg::COUNT_W-1:0] plugged_count;
  logic table_full;

  assign in_ready = !q_full;
  assign q_push = in_valid && !q_full;
  assign table_full = plugged_count >= tct_pkg::COUNT_W'(tct_pkg::SLOT_COUNT);

  always_comb begin
    q_cmd.accel_x = accel_x;
    q_cmd.accel_y = accel_y;
    q_cmd.accel_z = accel_z;
    q_cmd.gyro_z = gyro_z;
    q_cmd.slot = slot_index;
    if (req_type) begin
      if (table_full) begin
        q_cmd.kind = tct_pkg::ST_FULL;
      end else begin
        q_cmd.kind = tct_pkg::ST_PLUGGED;
        q_cmd.slot = plugged_count[tct_pkg::SLOT_W-1:0];
      end
    end else if (tct_pkg::COUNT_W'(slot_index) >= plugged_count) begin
      q_cmd.kind = tct_pkg::ST_NO_SLOT;
    end else begin
      q_cmd.kind = tct_pkg::ST_MOVED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      plugged_count <= '0;
    end else if (q_push && req_type && !table_full) begin
      plugged_count <= plugged_count + 1'b1;
    end
  end

endmodule

### design/tct_queue.sv
// short command queue between front and back end
module tct_queue (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  tct_pkg::cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic not_empty,
  output tct_pkg::cmd_t head
);

  tct_pkg::cmd_t entries [tct_pkg::QUEUE_DEPTH];
  logic wr_ptr;
  logic rd_ptr;
  logic [1:0] fill;

  assign full = fill == 2'(tct_pkg::QUEUE_DEPTH);
  assign not_empty = fill != 2'd0;
  assign head = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill <= '0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

### design/tct_cordic.sv
// iterative cordic vectoring unit for atan2 in q8 degrees
module tct_cordic (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic signed [tct_pkg::ANGLE_W-1:0] y_in,
  input  logic signed [tct_pkg::ANGLE_W-1:0] x_in,
  output logic done,
  output logic signed [tct_pkg::ANGLE_W-1:0] angle
);

  logic busy;
  logic finish;
  logic [tct_pkg::STEP_W-1:0] step;
  logic signed [tct_pkg::VEC_W-1:0] x;
  logic signed [tct_pkg::VEC_W-1:0] y;
  logic signed [tct_pkg::Z_W-1:0] z;
  logic signed [tct_pkg::VEC_W-1:0] xs;
  logic signed [tct_pkg::VEC_W-1:0] ys;
  logic signed [tct_pkg::VEC_W-1:0] dx;
  logic signed [tct_pkg::VEC_W-1:0] dy;
  logic signed [tct_pkg::Z_W-1:0] z_round;
  logic signed [tct_pkg::Z_W-1:0] full_wide;

  assign xs = tct_pkg::VEC_W'(x_in) <<< 8;
  assign ys = tct_pkg::VEC_W'(y_in) <<< 8;
  assign dx = y >>> step;
  assign dy = x >>> step;
  assign z_round = (z + tct_pkg::Z_W'(128)) >>> (16 - tct_pkg::FRAC_BITS);
  assign full_wide = tct_pkg::Z_W'(tct_pkg::ANGLE_FULL);

  always_ff @(posedge clk) begin
    if (start) begin
      step <= '0;
      if (x_in < 0) begin
        if (y_in >= 0) begin
          x <= ys;
          y <= -xs;
          z <= tct_pkg::Z_QUARTER;
        end else begin
          x <= -ys;
          y <= xs;
          z <= -tct_pkg::Z_QUARTER;
        end
      end else begin
        x <= xs;
        y <= ys;
        z <= '0;
      end
    end else if (busy) begin
      step <= step + 1'b1;
      if (!y[tct_pkg::VEC_W-1]) begin
        x <= x + dx;
        y <= y - dy;
        z <= z + tct_pkg::atan_step(step);
      end else begin
        x <= x - dx;
        y <= y + dy;
        z <= z - tct_pkg::atan_step(step);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      if (y_in == 0) begin
        angle <= (x_in >= 0) ? '0 : tct_pkg::ANGLE_FULL;
      end else if (x_in == 0) begin
        angle <= (y_in > 0) ? tct_pkg::ANGLE_QUARTER : -tct_pkg::ANGLE_QUARTER;
      end
    end else if (finish) begin
      if (z_round > full_wide) begin
        angle <= tct_pkg::ANGLE_FULL;
      end else if (z_round < -full_wide) begin
        angle <= -tct_pkg::ANGLE_FULL;
      end else begin
        angle <= z_round[tct_pkg::ANGLE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      finish <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      finish <= 1'b0;
      if (start) begin
        if (y_in == 0 || x_in == 0) begin
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
        end
      end else if (busy && step == tct_pkg::STEP_W'(tct_pkg::CORDIC_STEPS - 1)) begin
        busy <= 1'b0;
        finish <= 1'b1;
      end else if (finish) begin
        done <= 1'b1;
      end
    end
  end

endmodule

### design/tct_back.sv
// back end: runs angles, moves and stores cursors, holds the result
module tct_back (
  input  logic clk,
  input  logic rst,
  input  logic [tct_pkg::LIMIT_W-1:0] lim_w,
  input  logic [tct_pkg::LIMIT_W-1:0] lim_h,
  input  logic [tct_pkg::GAIN_W-1:0] gain,
  input  logic q_not_empty,
  input  tct_pkg::cmd_t q_head,
  output logic q_pop,
  output logic out_valid,
  input  logic out_ready,
  output tct_pkg::status_t out_status,
  output logic [tct_pkg::SLOT_W-1:0] out_slot,
  output logic [tct_pkg::POS_W-1:0] out_x,
  output logic [tct_pkg::POS_W-1:0] out_y,
  output logic signed [tct_pkg::ANGLE_W-1:0] out_pitch,
  output logic signed [tct_pkg::ANGLE_W-1:0] out_roll,
  output logic signed [tct_pkg::SAMPLE_W-1:0] out_yaw
);

  tct_pkg::back_state_t state;
  tct_pkg::back_state_t state_next;
  tct_pkg::cmd_t cmd;

  logic [tct_pkg::POS_W-1:0] col_mem [tct_pkg::SLOT_COUNT];
  logic [tct_pkg::POS_W-1:0] row_mem [tct_pkg::SLOT_COUNT];
  logic [tct_pkg::POS_W-1:0] col_cur;
  logic [tct_pkg::POS_W-1:0] row_cur;

  logic cordic_start;
  logic cordic_done;
  logic signed [tct_pkg::ANGLE_W-1:0] cordic_y;
  logic signed [tct_pkg::ANGLE_W-1:0] cordic_x;
  logic signed [tct_pkg::ANGLE_W-1:0] cordic_angle;

  logic signed [tct_pkg::PROD_W-1:0] prod_col;
  logic signed [tct_pkg::PROD_W-1:0] prod_row;
  logic signed [tct_pkg::P_W-1:0] col_new;
  logic signed [tct_pkg::P_W-1:0] row_new;
  logic [tct_pkg::POS_W-1:0] col_clamp;
  logic [tct_pkg::POS_W-1:0] row_clamp;
  logic load_cmd;

  function automatic logic [tct_pkg::POS_W-1:0] clamp_pos(
    input logic signed [tct_pkg::P_W-1:0] p,
    input logic [tct_pkg::LIMIT_W-1:0] lim
  );
    logic [tct_pkg::POS_W-1:0] r;
    if (p < 0) begin
      r = '0;
    end else if (p >= tct_pkg::P_W'(lim)) begin
      r = tct_pkg::POS_W'(lim - 1'b1);
    end else begin
      r = p[tct_pkg::POS_W-1:0];
    end
    return r;
  endfunction

  // truncate toward zero when dropping the fraction bits
  function automatic logic signed [tct_pkg::P_W-1:0] move_by(
    input logic [tct_pkg::POS_W-1:0] pos,
    input logic signed [tct_pkg::PROD_W-1:0] prod
  );
    logic signed [tct_pkg::PROD_W-1:0] biased;
    logic signed [tct_pkg::PROD_W-1:0] delta;
    biased = prod + (prod < 0 ? tct_pkg::PROD_W'(255) : tct_pkg::PROD_W'(0));
    delta = biased >>> tct_pkg::FRAC_BITS;
    return tct_pkg::P_W'(pos) + tct_pkg::P_W'(delta);
  endfunction

  tct_cordic u_cordic (
    .clk(clk),
    .rst(rst),
    .start(cordic_start),
    .y_in(cordic_y),
    .x_in(cordic_x),
    .done(cordic_done),
    .angle(cordic_angle)
  );

  assign col_cur = col_mem[cmd.slot];
  assign row_cur = row_mem[cmd.slot];
  assign col_new = move_by(col_cur, prod_col);
  assign row_new = move_by(row_cur, prod_row);
  assign col_clamp = clamp_pos(col_new, lim_w);
  assign row_clamp = clamp_pos(row_new, lim_h);

  always_comb begin
    state_next = state;
    case (state)
      tct_pkg::B_IDLE: begin
        if (q_not_empty) begin
          state_next = (q_head.kind == tct_pkg::ST_MOVED) ? tct_pkg::B_PITCH : tct_pkg::B_DONE;
        end
      end
      tct_pkg::B_PITCH: if (cordic_done) state_next = tct_pkg::B_ROLL;
      tct_pkg::B_ROLL: if (cordic_done) state_next = tct_pkg::B_SCALE;
      tct_pkg::B_SCALE: state_next = tct_pkg::B_MOVE;
      tct_pkg::B_MOVE: state_next = tct_pkg::B_DONE;
      tct_pkg::B_DONE: if (out_ready) state_next = tct_pkg::B_IDLE;
      default: state_next = tct_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    q_pop = 1'b0;
    load_cmd = 1'b0;
    cordic_start = 1'b0;
    cordic_y = tct_pkg::ANGLE_W'(q_head.accel_y);
    cordic_x = tct_pkg::ANGLE_W'(q_head.accel_z);
    out_valid = 1'b0;
    case (state)
      tct_pkg::B_IDLE: begin
        q_pop = q_not_empty;
        load_cmd = q_not_empty;
        cordic_start = q_not_empty && q_head.kind == tct_pkg::ST_MOVED;
      end
      tct_pkg::B_PITCH: begin
        cordic_start = cordic_done;
        cordic_y = -tct_pkg::ANGLE_W'(cmd.accel_x);
        cordic_x = tct_pkg::ANGLE_W'(cmd.accel_z);
      end
      tct_pkg::B_DONE: out_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tct_pkg::B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load_cmd) begin
      cmd <= q_head;
      out_status <= q_head.kind;
      out_slot <= (q_head.kind == tct_pkg::ST_FULL) ? '0 : q_head.slot;
      out_x <= (q_head.kind == tct_pkg::ST_PLUGGED) ? lim_w[tct_pkg::LIMIT_W-1:1] : '0;
      out_y <= (q_head.kind == tct_pkg::ST_PLUGGED) ? lim_h[tct_pkg::LIMIT_W-1:1] : '0;
      out_pitch <= '0;
      out_roll <= '0;
      out_yaw <= '0;
    end
    if (state == tct_pkg::B_PITCH && cordic_done) begin
      out_pitch <= cordic_angle;
    end
    if (state == tct_pkg::B_ROLL && cordic_done) begin
      out_roll <= cordic_angle;
    end
    if (state == tct_pkg::B_SCALE) begin
      prod_col <= out_roll * $signed({1'b0, gain});
      prod_row <= out_pitch * $signed({1'b0, gain});
    end
    if (state == tct_pkg::B_MOVE) begin
      out_x <= col_clamp;
      out_y <= row_clamp;
      out_yaw <= cmd.gyro_z;
    end
  end

  // cursor store, no reset: only plugged slots are ever read
  always_ff @(posedge clk) begin
    if (load_cmd && q_head.kind == tct_pkg::ST_PLUGGED) begin
      col_mem[q_head.slot] <= lim_w[tct_pkg::LIMIT_W-1:1];
      row_mem[q_head.slot] <= lim_h[tct_pkg::LIMIT_W-1:1];
    end else if (state == tct_pkg::B_MOVE) begin
      col_mem[cmd.slot] <= col_clamp;
      row_mem[cmd.slot] <= row_clamp;
    end
  end

endmodule

### design/tilt_cursor_tracker_top.sv
// top level of the tilt cursor tracker: ports, configuration registers, front, queue, back
//
// tilt cursor tracker: keeps a screen cursor for up to eight controller slots.
// a plug request (tuser = 1) takes the next free slot and centers its cursor,
// or reports a full table; a motion sample (tuser = 0) for a plugged slot
// turns the accelerometer reading into pitch = atan2(ay, az) and
// roll = atan2(-ax, az), in q8 degrees, moves the cursor by angle times gain
// (truncated toward zero) and clamps it to the screen. gyro z comes back as
// yaw. every request gives exactly one result transfer. after the pop, a motion
// sample runs through the pitch and roll states, two 16-step atan2 passes one
// after the other on the shared cordic unit, then the scale and move states,
// before its result is held valid; plug, table-full and unplugged-slot
// requests go from the pop straight to the result. a two-entry queue lets the
// front end keep taking transfers while a result waits on the output.
// configuration writes are taken at any time but must only be made while the
// block is idle; a screen limit of 0 acts as 1 and one above 4096 acts as 4096.
module tilt_cursor_tracker_top (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // slot_index, accel_x, accel_y, accel_z, gyro_z, zero fill
  input  logic s_axis_tuser,         // req_type
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  output logic [79:0] m_axis_tdata,  // slot_out, cursor_x, cursor_y, pitch, roll, yaw_rate, zero fill
  output logic [1:0] m_axis_tuser,   // status
  input  logic cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [12:0] cfg_data
);

  logic [tct_pkg::LIMIT_W-1:0] screen_width;
  logic [tct_pkg::LIMIT_W-1:0] screen_height;
  logic [tct_pkg::GAIN_W-1:0] motion_gain;
  logic [tct_pkg::LIMIT_W-1:0] lim_w;
  logic [tct_pkg::LIMIT_W-1:0] lim_h;

  logic q_full;
  logic q_push;
  logic q_pop;
  logic q_not_empty;
  tct_pkg::cmd_t push_cmd;
  tct_pkg::cmd_t q_head;

  tct_pkg::status_t out_status;
  logic [tct_pkg::SLOT_W-1:0] out_slot;
  logic [tct_pkg::POS_W-1:0] out_x;
  logic [tct_pkg::POS_W-1:0] out_y;
  logic signed [tct_pkg::ANGLE_W-1:0] out_pitch;
  logic signed [tct_pkg::ANGLE_W-1:0] out_roll;
  logic signed [tct_pkg::SAMPLE_W-1:0] out_yaw;

  // configuration registers, no read-back
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width <= 13'd1280;
      screen_height <= 13'd720;
      motion_gain <= 6'd5;
    end else if (cfg_we) begin
      case (cfg_index)
        tct_pkg::REG_SCREEN_WIDTH: screen_width <= cfg_data;
        tct_pkg::REG_SCREEN_HEIGHT: screen_height <= cfg_data;
        tct_pkg::REG_MOTION_GAIN: motion_gain <= cfg_data[tct_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // effective limits: zero acts as one, oversize saturates
  always_comb begin
    lim_w = screen_width;
    if (screen_width == '0) lim_w = 13'd1;
    else if (screen_width > tct_pkg::LIMIT_MAX) lim_w = tct_pkg::LIMIT_MAX;
    lim_h = screen_height;
    if (screen_height == '0) lim_h = 13'd1;
    else if (screen_height > tct_pkg::LIMIT_MAX) lim_h = tct_pkg::LIMIT_MAX;
  end

  tct_front u_front (
    .clk(clk),
    .rst(rst),
    .in_valid(s_axis_tvalid),
    .in_ready(s_axis_tready),
    .req_type(s_axis_tuser),
    .slot_index(s_axis_tdata[2:0]),
    .accel_x(s_axis_tdata[18:3]),
    .accel_y(s_axis_tdata[34:19]),
    .accel_z(s_axis_tdata[50:35]),
    .gyro_z(s_axis_tdata[66:51]),
    .q_full(q_full),
    .q_push(q_push),
    .q_cmd(push_cmd)
  );

  tct_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(q_push),
    .push_cmd(push_cmd),
    .full(q_full),
    .pop(q_pop),
    .not_empty(q_not_empty),
    .head(q_head)
  );

  tct_back u_back (
    .clk(clk),
    .rst(rst),
    .lim_w(lim_w),
    .lim_h(lim_h),
    .gain(motion_gain),
    .q_not_empty(q_not_empty),
    .q_head(q_head),
    .q_pop(q_pop),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_status(out_status),
    .out_slot(out_slot),
    .out_x(out_x),
    .out_y(out_y),
    .out_pitch(out_pitch),
    .out_roll(out_roll),
    .out_yaw(out_yaw)
  );

  assign m_axis_tuser = out_status;
  assign m_axis_tdata = {3'b000, out_yaw, out_roll, out_pitch, out_y, out_x, out_slot};

endmodule

### verif/tilt_cursor_tracker_top_test.sv
// testbench of the tilt cursor tracker: directed and random requests checked against a predictor
`timescale 1ns / 100ps

module tilt_cursor_tracker_top_test;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [71:0] s_axis_tdata = '0;  // slot_index, accel_x, accel_y, accel_z, gyro_z, zero fill
  logic s_axis_tuser = 1'b0;       // req_type
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;       // slot_out, cursor_x, cursor_y, pitch, roll, yaw_rate, zero fill
  logic [1:0] m_axis_tuser;        // status
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [12:0] cfg_data = '0;

  tilt_cursor_tracker_top dut (.*);

  always #10 clk = ~clk;

  // expected result of one request
  typedef struct packed {
    tct_pkg::status_t kind;
    logic [2:0] slot;
    logic [11:0] col;
    logic [11:0] row;
    logic signed [16:0] pitch;
    logic signed [16:0] roll;
    logic signed [15:0] yaw;
  } tilt_result_t;

  tilt_result_t pending_results[$];
  int errors = 0;
  int cycles = 0;
  bit sink_stall_on = 1'b1;

  // predictor copy of the block's registers and table
  logic [12:0] width_reg, height_reg;
  logic [5:0] gain_reg;
  int plugged;
  int col_tab[8];
  int row_tab[8];

  localparam longint ATAN_Q16[16] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
    58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;  // arithmetic shift is floor division by a power of two
  endfunction

  // cordic vectoring atan2 in q8 degrees
  function automatic longint tilt_angle(longint y, longint x);
    longint z, t, dx, dy, r;
    longint full;
    full = 180 * 256;
    z = 0;
    if (y == 0) return (x >= 0) ? 0 : full;
    if (x == 0) return (y > 0) ? 90 * 256 : -90 * 256;
    x = x * 256;
    y = y * 256;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = 90 * 65536;
      end else begin
        x = -y; y = t; z = -90 * 65536;
      end
    end
    for (int i = 0; i < 16; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (y >= 0) begin
        x += dx; y -= dy; z += ATAN_Q16[i];
      end else begin
        x -= dx; y += dy; z -= ATAN_Q16[i];
      end
    end
    r = floor_shr(z + 128, 8);
    if (r > full) r = full;
    if (r < -full) r = -full;
    return r;
  endfunction

  function automatic int clamp_limit(logic [12:0] r);
    if (r == 0) return 1;
    if (r > 4096) return 4096;
    return int'(r);
  endfunction

  function automatic int moved_pos(int pos, longint angle, int limit);
    longint d, p;
    d = (angle * longint'(gain_reg)) / 256;  // truncates toward zero
    p = pos + d;
    if (p < 0) p = 0;
    if (p >= limit) p = limit - 1;
    return int'(p);
  endfunction

  function automatic tilt_result_t predict_request(bit plug, logic [2:0] slot,
      logic signed [15:0] ax, logic signed [15:0] ay, logic signed [15:0] az,
      logic signed [15:0] gz);
    tilt_result_t r;
    int lw, lh;
    longint p, q;
    r = '0;
    lw = clamp_limit(width_reg);
    lh = clamp_limit(height_reg);
    if (plug) begin
      if (plugged >= 8) begin
        r.kind = tct_pkg::ST_FULL;
        return r;
      end
      col_tab[plugged] = lw / 2;
      row_tab[plugged] = lh / 2;
      r.kind = tct_pkg::ST_PLUGGED;
      r.slot = 3'(plugged);
      r.col = 12'(col_tab[plugged]);
      r.row = 12'(row_tab[plugged]);
      plugged++;
      return r;
    end
    r.slot = slot;
    if (slot >= plugged) begin
      r.kind = tct_pkg::ST_NO_SLOT;
      return r;
    end
    p = tilt_angle(ay, az);
    q = tilt_angle(-longint'(ax), az);
    col_tab[slot] = moved_pos(col_tab[slot], q, lw);
    row_tab[slot] = moved_pos(row_tab[slot], p, lh);
    r.kind = tct_pkg::ST_MOVED;
    r.col = 12'(col_tab[slot]);
    r.row = 12'(row_tab[slot]);
    r.pitch = 17'(p);
    r.roll = 17'(q);
    r.yaw = gz;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  function automatic int gap_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 55) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // result side: random ready while stalls are on, check every transfer
  always @(negedge clk) begin
    if (!rst) m_axis_tready <= !sink_stall_on || ($urandom_range(0, 99) < 70);
  end

  always @(posedge clk) begin
    tilt_result_t want;
    cycles++;
    if (cycles > 1500000) begin
      $display("timeout at cycle %0d", cycles);
      $display("RESULT: ERROR");
      $finish;
    end
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $display("unexpected result transfer at cycle %0d", cycles);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tuser != want.kind) report_mismatch("status", m_axis_tuser, want.kind);
        if (m_axis_tdata[2:0] != want.slot) report_mismatch("slot", m_axis_tdata[2:0], want.slot);
        if (m_axis_tdata[14:3] != want.col) report_mismatch("cursor_x", m_axis_tdata[14:3], want.col);
        if (m_axis_tdata[26:15] != want.row)
          report_mismatch("cursor_y", m_axis_tdata[26:15], want.row);
        if ($signed(m_axis_tdata[43:27]) != want.pitch)
          report_mismatch("pitch", $signed(m_axis_tdata[43:27]), want.pitch);
        if ($signed(m_axis_tdata[60:44]) != want.roll)
          report_mismatch("roll", $signed(m_axis_tdata[60:44]), want.roll);
        if ($signed(m_axis_tdata[76:61]) != want.yaw)
          report_mismatch("yaw", $signed(m_axis_tdata[76:61]), want.yaw);
        if (m_axis_tdata[79:77] != 3'd0) report_mismatch("fill", m_axis_tdata[79:77], 0);
      end
    end
  end

  // one request transfer, predicted when taken
  task automatic send_request(bit plug, logic [2:0] slot, logic signed [15:0] ax,
      logic signed [15:0] ay, logic signed [15:0] az, logic signed [15:0] gz,
      bit no_gap = 1'b0);
    int g;
    g = no_gap ? 0 : gap_len();
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= plug;
    s_axis_tdata <= {8'd0, gz, az, ay, ax, slot};
    do @(posedge clk); while (!s_axis_tready);
    pending_results.push_back(predict_request(plug, slot, ax, ay, az, gz));
    @(negedge clk);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  // registers only change with the block idle
  task automatic write_reg(logic [1:0] idx, logic [12:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      tct_pkg::REG_SCREEN_WIDTH: width_reg = val;
      tct_pkg::REG_SCREEN_HEIGHT: height_reg = val;
      tct_pkg::REG_MOTION_GAIN: gain_reg = val[5:0];
      default: ;
    endcase
  endtask

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'($urandom_range(0, 64) - 32);
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic send_motion(logic [2:0] slot);
    send_request(1'b0, slot, rand_sample(), rand_sample(), rand_sample(), 16'($urandom()));
  endtask

  // a motion sample with nothing plugged, then plug requests until full, then one more that overflows
  task automatic test_plug_and_full();
    send_request(1'b0, 3'd0, 16'sd100, 16'sd100, 16'sd100, 16'sd5);  // nothing plugged yet
    for (int i = 0; i < 9; i++)
      send_request(1'b1, 3'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom()),
        16'($urandom()));
  endtask

  // axis cases and field extremes
  task automatic test_angle_corners();
    send_request(1'b0, 3'd0, 16'sd0, 16'sd0, 16'sd0, 16'sh7fff);
    send_request(1'b0, 3'd1, 16'sd0, 16'sd0, -16'sd500, 16'sh8000);
    send_request(1'b0, 3'd2, 16'sd300, -16'sd300, 16'sd0, 16'sd1);
    send_request(1'b0, 3'd3, -16'sd300, 16'sd300, 16'sd0, -16'sd1);
    send_request(1'b0, 3'd4, 16'sh8000, 16'sh8000, 16'sh8000, 16'sd0);
    send_request(1'b0, 3'd5, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sd0);
    send_request(1'b0, 3'd6, 16'sh7fff, 16'sh8000, -16'sd1, 16'sd0);
    send_request(1'b0, 3'd7, 16'sh8000, 16'sd1, -16'sd1, 16'sd0);
    send_request(1'b0, 3'd7, 16'sd1, -16'sd1, 16'sd1, 16'sd0);
  endtask

  // random motion, with the odd random request, under one register setting
  task automatic test_random_motion(int count, logic [12:0] w, logic [12:0] h, logic [5:0] g);
    write_reg(tct_pkg::REG_SCREEN_WIDTH, w);
    write_reg(tct_pkg::REG_SCREEN_HEIGHT, h);
    write_reg(tct_pkg::REG_MOTION_GAIN, {7'd0, g});
    write_reg(2'd3, 13'($urandom()));  // unused index, ignored
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 19) == 0)
        send_request(1'($urandom()), 3'($urandom()), 16'($urandom()), 16'($urandom()),
          16'($urandom()), 16'($urandom()));
      else
        send_motion(3'($urandom_range(0, 7)));
    end
    wait_drained();
  endtask

  // back to back requests with the sink always ready
  task automatic test_partial_table();
    sink_stall_on = 1'b0;
    for (int i = 0; i < 40; i++) send_request(1'b0, 3'($urandom()), 16'($urandom()),
      16'($urandom()), 16'($urandom()), 16'($urandom()), 1'b1);
    sink_stall_on = 1'b1;
    wait_drained();
  endtask

  initial begin
    width_reg = 13'd1280;
    height_reg = 13'd720;
    gain_reg = 6'd5;
    plugged = 0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_plug_and_full();
    test_angle_corners();
    wait_drained();
    test_random_motion(300, 13'd1280, 13'd720, 6'd5);
    test_random_motion(200, 13'd0, 13'd8191, 6'd63);
    test_random_motion(200, 13'd4096, 13'd1, 6'd0);
    test_random_motion(300, 13'd4097, 13'd4096, 6'd1);
    test_random_motion(250, 13'($urandom_range(1, 4096)), 13'($urandom_range(1, 4096)),
      6'($urandom()));
    test_partial_table();
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
